@@ design/rle_pkg.sv @@
// rle_pkg: constants shared by the rsa letter block
// no dependencies
package rle_pkg;

   localparam int PRIME_BITS_DEF = 8;
   localparam int RESET_P = 11;
   localparam int RESET_Q = 17;
   localparam int LETTER_OFS = 96;
   localparam int LETTER_LO = 97;
   localparam int LETTER_HI = 122;
   localparam int CSR_IDX_W = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRIME_P = 4'd0,
      CSR_PRIME_Q = 4'd1
   } csr_idx_type;

endpackage

@@ design/rle_rem.sv @@
// rle_rem: bit-serial restoring remainder unit, one dividend bit per cycle
// depends on nothing outside this file
module rle_rem #(
   parameter int NW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [2*NW-1:0] dividend,
   input  logic [NW-1:0] divisor,
   output logic          done,
   output logic [NW-1:0] remainder
);
   localparam int DW = 2 * NW;
   localparam int CW = $clog2(DW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] num_ff;
   logic [NW-1:0] div_ff;
   logic [NW-1:0] rem_ff;
   logic [NW:0]   shifted;
   logic [NW:0]   diff;
   logic [NW-1:0] rem_in;

   always_comb begin
      shifted = {rem_ff, num_ff[DW-1]};
      diff    = shifted - {1'b0, div_ff};
      rem_in  = (shifted >= {1'b0, div_ff}) ? diff[NW-1:0] : shifted[NW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(DW);
            num_ff  <= dividend;
            div_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            num_ff <= num_ff << 1;
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

@@ design/rle_seq.sv @@
// rle_seq: sequencer for key derivation and the two modular powers
// depends on rle_pkg and the shared remainder unit rle_rem
module rle_seq #(
   parameter int PW = rle_pkg::PRIME_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          cfg_wr,
   input  logic [PW-1:0] prime_p,
   input  logic [PW-1:0] prime_q,
   input  logic          start,
   input  logic [7:0]    letter,
   output logic          busy,
   output logic          rsp_valid,
   output logic [15:0]   rsp_cipher_value,
   output logic [7:0]    rsp_decrypted_letter,
   output logic          rsp_bad_input
);
   import rle_pkg::*;

   localparam int NW = 2 * PW;

   typedef enum logic [3:0] {
      S_IDLE, S_N, S_PHI, S_CHK, S_E_TEST, S_GCD, S_GCD_WAIT,
      S_D_INIT, S_D_STEP, S_X_TEST, S_X_RED, S_X_WAIT
   } state_type;

   state_type     state_ff;
   logic          stale_ff;
   logic [NW-1:0] n_ff, phi_ff, e_ff, d_ff, i_ff, a_ff, b_ff, r_ff;
   logic [NW-1:0] acc_ff, base_ff, ex_ff, cipher_ff;
   logic [2*NW-1:0] prod_ff;
   logic          tgt_ff, phase_ff;
   logic          valid_ff, bad_ff;
   logic [15:0]   cv_ff;
   logic [7:0]    dl_ff;

   logic [NW-1:0]   op_a, op_b;
   logic [2*NW-1:0] prod_in;
   logic            rem_start, rem_done;
   logic [2*NW-1:0] rem_num;
   logic [NW-1:0]   rem_div, rem_val;
   logic [NW:0]     r_init, r_sum;
   logic            bad_letter;
   logic [NW+15:0]  cipher_ext;
   logic [NW+7:0]   plain_ext;

   // single shared multiplier
   always_comb begin
      priority if (state_ff == S_N) begin
         op_a = NW'(prime_p);
         op_b = NW'(prime_q);
      end else if (state_ff == S_PHI) begin
         op_a = NW'(prime_p - PW'(1));
         op_b = NW'(prime_q - PW'(1));
      end else if (state_ff == S_X_WAIT) begin
         op_a = base_ff;
         op_b = base_ff;
      end else begin
         op_a = ex_ff[0] ? acc_ff : base_ff;
         op_b = base_ff;
      end
      prod_in = op_a * op_b;
   end

   always_comb begin
      rem_start = ((state_ff == S_GCD) && (b_ff != '0)) || (state_ff == S_X_RED);
      rem_num   = (state_ff == S_GCD) ? {{NW{1'b0}}, a_ff} : prod_ff;
      rem_div   = (state_ff == S_GCD) ? b_ff : n_ff;
      r_init    = {e_ff, 1'b0} - (NW+1)'(1);
      r_sum     = {1'b0, r_ff} + {1'b0, e_ff};
      bad_letter = (letter < 8'(LETTER_LO)) || (letter > 8'(LETTER_HI));
      cipher_ext = {16'b0, cipher_ff};
      plain_ext  = {8'b0, acc_ff};
   end

   rle_rem #(.NW(NW)) u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (rem_num),
      .divisor   (rem_div),
      .done      (rem_done),
      .remainder (rem_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         stale_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (stale_ff) begin
                  stale_ff <= 1'b0;
                  prod_ff  <= prod_in;
                  state_ff <= S_N;
               end else if (start) begin
                  if (bad_letter) begin
                     valid_ff <= 1'b1;
                     bad_ff   <= 1'b1;
                     cv_ff    <= '0;
                     dl_ff    <= '0;
                  end else if (n_ff == '0) begin
                     valid_ff <= 1'b1;
                     bad_ff   <= 1'b0;
                     cv_ff    <= '0;
                     dl_ff    <= 8'(LETTER_OFS);
                  end else begin
                     acc_ff   <= NW'(1);
                     base_ff  <= NW'(letter - 8'(LETTER_OFS));
                     ex_ff    <= e_ff;
                     phase_ff <= 1'b0;
                     state_ff <= S_X_TEST;
                  end
               end
            end
            S_N: begin
               prod_ff  <= prod_in;
               state_ff <= S_PHI;
            end
            S_PHI: begin
               n_ff     <= prod_ff[NW-1:0];
               prod_ff  <= prod_in;
               state_ff <= S_CHK;
            end
            S_CHK: begin
               phi_ff <= prod_ff[NW-1:0];
               if ((prime_p >= PW'(2)) && (prime_q >= PW'(2)) &&
                   (prod_ff[NW-1:0] > NW'(2))) begin
                  i_ff     <= NW'(2);
                  state_ff <= S_E_TEST;
               end else begin
                  e_ff     <= NW'(2);
                  d_ff     <= NW'(2);
                  state_ff <= S_IDLE;
               end
            end
            S_E_TEST: begin
               if (i_ff >= phi_ff) begin
                  e_ff     <= phi_ff;
                  state_ff <= S_D_INIT;
               end else begin
                  a_ff     <= phi_ff;
                  b_ff     <= i_ff;
                  state_ff <= S_GCD;
               end
            end
            S_GCD: begin
               if (b_ff == '0) begin
                  if (a_ff == NW'(1)) begin
                     e_ff     <= i_ff;
                     state_ff <= S_D_INIT;
                  end else begin
                     i_ff     <= i_ff + NW'(1);
                     state_ff <= S_E_TEST;
                  end
               end else begin
                  state_ff <= S_GCD_WAIT;
               end
            end
            S_GCD_WAIT: begin
               if (rem_done) begin
                  a_ff     <= b_ff;
                  b_ff     <= rem_val;
                  state_ff <= S_GCD;
               end
            end
            S_D_INIT: begin
               r_ff     <= (r_init >= {1'b0, phi_ff}) ? NW'(r_init - {1'b0, phi_ff})
                                                      : r_init[NW-1:0];
               i_ff     <= NW'(2);
               state_ff <= S_D_STEP;
            end
            S_D_STEP: begin
               if (i_ff >= phi_ff) begin
                  d_ff     <= phi_ff;
                  state_ff <= S_IDLE;
               end else if (r_ff == '0) begin
                  d_ff     <= i_ff;
                  state_ff <= S_IDLE;
               end else begin
                  r_ff <= (r_sum >= {1'b0, phi_ff}) ? NW'(r_sum - {1'b0, phi_ff})
                                                    : r_sum[NW-1:0];
                  i_ff <= i_ff + NW'(1);
               end
            end
            S_X_TEST: begin
               if (ex_ff == '0) begin
                  if (!phase_ff) begin
                     cipher_ff <= acc_ff;
                     base_ff   <= acc_ff;
                     acc_ff    <= NW'(1);
                     ex_ff     <= d_ff;
                     phase_ff  <= 1'b1;
                  end else begin
                     valid_ff <= 1'b1;
                     bad_ff   <= 1'b0;
                     cv_ff    <= cipher_ext[15:0];
                     dl_ff    <= plain_ext[7:0] + 8'(LETTER_OFS);
                     state_ff <= S_IDLE;
                  end
               end else begin
                  prod_ff  <= prod_in;
                  tgt_ff   <= ex_ff[0];
                  state_ff <= S_X_RED;
               end
            end
            S_X_RED: begin
               state_ff <= S_X_WAIT;
            end
            S_X_WAIT: begin
               if (rem_done) begin
                  if (tgt_ff) begin
                     acc_ff   <= rem_val;
                     prod_ff  <= prod_in;
                     tgt_ff   <= 1'b0;
                     state_ff <= S_X_RED;
                  end else begin
                     base_ff  <= rem_val;
                     ex_ff    <= ex_ff >> 1;
                     state_ff <= S_X_TEST;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (cfg_wr) begin
            stale_ff <= 1'b1;
         end
      end
   end

   assign busy                 = (state_ff != S_IDLE) || stale_ff;
   assign rsp_valid            = valid_ff;
   assign rsp_cipher_value     = cv_ff;
   assign rsp_decrypted_letter = dl_ff;
   assign rsp_bad_input        = bad_ff;

endmodule

@@ design/rsa_letter_encrypt_decrypt.sv @@
// rsa_letter_encrypt_decrypt: top level with prime registers, depends on rle_pkg, rle_seq, rle_rem
// each request runs a modular power with e, then one with d, one step per exponent bit,
// each step a reduction of the squared base, with a multiply and reduction first for a set bit
// bad letters and a zero modulus: result taken in the cycle after the accepting edge
// throughput: one request at a time, the next one accepted at the edge that takes the result
// reset and prime writes hold busy high while e and d are derived again; results never stall
module rsa_letter_encrypt_decrypt #(
   parameter int PRIME_BITS = rle_pkg::PRIME_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [7:0]                   req_letter,
   output logic                         rsp_valid,
   output logic [15:0]                  rsp_cipher_value,
   output logic [7:0]                   rsp_decrypted_letter,
   output logic                         rsp_bad_input,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rle_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [PRIME_BITS-1:0]        csr_wdata
);
   import rle_pkg::*;

   logic [PRIME_BITS-1:0] prime_p_ff;
   logic [PRIME_BITS-1:0] prime_q_ff;
   logic                  csr_wr;
   logic                  cfg_wr;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign cfg_wr    = csr_wr && ((csr_index == CSR_PRIME_P) || (csr_index == CSR_PRIME_Q));

   always_ff @(posedge clock) begin
      if (reset) begin
         prime_p_ff <= PRIME_BITS'(RESET_P);
         prime_q_ff <= PRIME_BITS'(RESET_Q);
      end else if (csr_wr) begin
         if (csr_index == CSR_PRIME_P) begin
            prime_p_ff <= csr_wdata;
         end else if (csr_index == CSR_PRIME_Q) begin
            prime_q_ff <= csr_wdata;
         end
      end
   end

   rle_seq #(.PW(PRIME_BITS)) u_seq (
      .clock                (clock),
      .reset                (reset),
      .cfg_wr               (cfg_wr),
      .prime_p              (prime_p_ff),
      .prime_q              (prime_q_ff),
      .start                (start),
      .letter               (req_letter),
      .busy                 (busy),
      .rsp_valid            (rsp_valid),
      .rsp_cipher_value     (rsp_cipher_value),
      .rsp_decrypted_letter (rsp_decrypted_letter),
      .rsp_bad_input        (rsp_bad_input)
   );

endmodule

@@ tb/sv/testbench.sv @@
// testbench: checks rsa_letter_encrypt_decrypt against its own rsa key and power predictor
// depends on rle_pkg and the design files; queued requests, random gaps, prime reconfiguration
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import rle_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 4'd15;

   typedef struct {
      logic [15:0] cipher;
      logic [7:0]  plain_letter;
      logic        bad;
   } rsa_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [7:0] req_letter = '0;
   logic rsp_valid;
   logic [15:0] rsp_cipher_value;
   logic [7:0] rsp_decrypted_letter;
   logic rsp_bad_input;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [PRIME_BITS_DEF-1:0] csr_wdata = '0;

   logic [7:0] letter_q[$];
   rsa_result_type result_q[$];
   int gap_cnt = 0;
   bit no_gaps = 0;
   bit failed = 0;

   longint prime_p = RESET_P;
   longint prime_q = RESET_Q;
   longint key_n, key_e, key_d;

   rsa_letter_encrypt_decrypt DUT (.*);

   always #2 clock = ~clock;

   function automatic longint gcd_of(longint a, longint b);
      longint t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic void derive_keys();
      longint phi;
      longint i;
      phi = (prime_p - 1) * (prime_q - 1);
      key_n = prime_p * prime_q;
      if (phi <= 2) begin
         key_e = 2;
         key_d = 2;
         return;
      end
      for (i = 2; i < phi; i++)
         if (gcd_of(i, phi) == 1) break;
      key_e = i;
      for (i = 2; i < phi; i++)
         if ((key_e * i - 1) % phi == 0) break;
      key_d = i;
   endfunction

   function automatic longint reduce_n(longint x);
      return key_n == 0 ? 0 : x % key_n;
   endfunction

   function automatic longint power_mod_n(longint base, longint ex);
      longint acc;
      longint b;
      acc = reduce_n(1);
      b = reduce_n(base);
      while (ex != 0) begin
         if (ex[0]) acc = reduce_n(acc * b);
         b = reduce_n(b * b);
         ex = ex >> 1;
      end
      return acc;
   endfunction

   function automatic rsa_result_type encrypt_decrypt(logic [7:0] letter);
      rsa_result_type r;
      longint c;
      longint m;
      if (letter < LETTER_LO || letter > LETTER_HI) begin
         r.cipher = '0;
         r.plain_letter = '0;
         r.bad = 1'b1;
         return r;
      end
      m = letter - LETTER_OFS;
      c = power_mod_n(m, key_e);
      r.cipher = c[15:0];
      r.plain_letter = 8'(power_mod_n(c, key_d) + LETTER_OFS);
      r.bad = 1'b0;
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      if (no_gaps) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_cnt <= 0;
      end else begin
         if (start && !busy) result_q.push_back(encrypt_decrypt(req_letter));
         if (!start || !busy) begin
            if (gap_cnt > 0) begin
               gap_cnt <= gap_cnt - 1;
               start <= 1'b0;
            end else if (letter_q.size() > 0) begin
               req_letter <= letter_q.pop_front();
               start <= 1'b1;
               gap_cnt <= pick_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsa_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (result_q.size() == 0) begin
            $display("%t unexpected result cipher=%h letter=%h bad=%b", $realtime,
               rsp_cipher_value, rsp_decrypted_letter, rsp_bad_input);
            failed = 1;
         end else begin
            exp_r = result_q.pop_front();
            if (rsp_cipher_value !== exp_r.cipher) begin
               $display("%t cipher exp %h got %h", $realtime, exp_r.cipher, rsp_cipher_value);
               failed = 1;
            end
            if (rsp_decrypted_letter !== exp_r.plain_letter) begin
               $display("%t letter exp %h got %h", $realtime, exp_r.plain_letter,
                  rsp_decrypted_letter);
               failed = 1;
            end
            if (rsp_bad_input !== exp_r.bad) begin
               $display("%t bad_input exp %b got %b", $realtime, exp_r.bad, rsp_bad_input);
               failed = 1;
            end
         end
      end
   end

   task automatic wait_idle();
      while (letter_q.size() > 0 || start || result_q.size() > 0) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_PRIME_P) prime_p = value;
      else if (idx == CSR_PRIME_Q) prime_q = value;
      derive_keys();
   endtask

   task automatic queue_random(int count);
      repeat (count) begin
         if ($urandom_range(0, 9) < 7) letter_q.push_back(8'($urandom_range(LETTER_LO, LETTER_HI)));
         else letter_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int cfg_p[12] = '{2, 0, 13, 3, 4, 7, 2, 61, 1, 255, 251, 5};
      int cfg_q[12] = '{2, 13, 0, 5, 6, 7, 3, 53, 200, 255, 241, 11};
      derive_keys();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      letter_q = '{8'd0, 8'd255, 8'd96, 8'd97, 8'd122, 8'd123, 8'd64, 8'd90, 8'd65, 8'd128,
                   8'd150, 8'd100, 8'd110, 8'd120, 8'd113, 8'd170, 8'd85};
      queue_random(100);
      wait_idle();
      csr_write(CSR_UNUSED_IDX, 8'd3);
      for (int k = 0; k < 12; k++) begin
         wait_idle();
         csr_write(CSR_PRIME_P, 8'(cfg_p[k]));
         csr_write(CSR_PRIME_Q, 8'(cfg_q[k]));
         no_gaps = (k % 4 == 1);
         queue_random((cfg_p[k] > 200) ? 10 : 95);
      end
      wait_idle();
      repeat (50) @(posedge clock);
      if (!failed) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   initial begin
      #400_000_000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
